[hw/rtl/orsb_pkg.sv]
package orsb_pkg;

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int LAP_W  = 32;
    localparam int IPOS_W = 4;
    localparam int LIM_W  = 7;

    // Item kinds
    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_READ  = 1'b1
    } t_kind;

    // Read sequencer states
    typedef enum logic [2:0] {
        RD_IDLE,
        RD_CATCH,
        RD_FILL,
        RD_LEN,
        RD_STREAM,
        RD_EMPTY
    } t_rd_state;

endpackage

[hw/rtl/overwrite_ring_slot_buffer.sv]
// Channel | Handshake               | Beat
// in      | i_in_valid / o_in_ready | write byte or read request (i_kind)
// out     | o_out_valid / i_out_ready | one read byte, or an empty marker
//
// Write beat: back to back while no read is in progress; the byte RAM takes it at
// the accept edge. Read beat: setup (lap catch-up, fill RAM read, byte count),
// then one byte per cycle from the byte RAM read port while the output is not
// stalled, or an empty marker. The input is held off from a read's accept until
// its last byte is issued. A stalled output holds the RAM read register; the next
// item may be accepted while the final beat still waits. No clearing pass at reset.
module overwrite_ring_slot_buffer #(
    parameter int SLOTS      = 8,
    parameter int SLOT_BYTES = 64
) (
    i_clk, i_rst_n,
    i_in_valid, o_in_ready,
    i_kind, i_wr_first, i_wr_length, i_wr_byte, i_rd_lap, i_rd_position, i_rd_max_bytes,
    o_out_valid, i_out_ready,
    o_rd_byte, o_rd_has_data, o_rd_last, o_out_lap, o_out_position
);
    import orsb_pkg::*;

    localparam int SW  = $clog2(SLOTS);
    localparam int PW  = SW + 1;
    localparam int BIW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int AW  = SW + BIW;
    localparam int FW  = $clog2(SLOT_BYTES + 1);

    input  logic                              i_clk;
    input  logic                              i_rst_n;
    input  logic                              i_in_valid;
    output logic                              o_in_ready;
    input  logic                              i_kind;
    input  logic                              i_wr_first;
    input  logic [orsb_pkg::LEN_W-1:0]        i_wr_length;
    input  logic [orsb_pkg::BYTE_W-1:0]       i_wr_byte;
    input  logic [orsb_pkg::LAP_W-1:0]        i_rd_lap;
    input  logic signed [orsb_pkg::IPOS_W-1:0] i_rd_position;
    input  logic [orsb_pkg::LIM_W-1:0]        i_rd_max_bytes;
    output logic                              o_out_valid;
    input  logic                              i_out_ready;
    output logic [orsb_pkg::BYTE_W-1:0]       o_rd_byte;
    output logic                              o_rd_has_data;
    output logic                              o_rd_last;
    output logic [orsb_pkg::LAP_W-1:0]        o_out_lap;
    output logic signed [orsb_pkg::IPOS_W-1:0] o_out_position;

    logic                 accept;
    logic                 wr_en;
    logic                 rd_req;
    logic                 rd_idle;
    logic signed [PW-1:0] wr_pos;
    logic [LAP_W-1:0]     wr_lap;
    logic                 st_wr_en;
    logic [AW-1:0]        st_wr_addr;
    logic [BYTE_W-1:0]    st_wr_data;
    logic                 st_rd_en;
    logic [AW-1:0]        st_rd_addr;
    logic [BYTE_W-1:0]    st_q;
    logic                 fl_wr_en;
    logic [SW-1:0]        fl_wr_addr;
    logic [FW-1:0]        fl_wr_data;
    logic                 fl_rd_en;
    logic [SW-1:0]        fl_rd_addr;
    logic [FW-1:0]        fl_q;

    // Input beat steering
    assign o_in_ready = rd_idle;
    assign accept     = i_in_valid && o_in_ready;
    assign wr_en      = accept && (i_kind == KIND_WRITE);
    assign rd_req     = accept && (i_kind == KIND_READ);

    orsb_writer #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_writer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (wr_en),
        .i_first   (i_wr_first),
        .i_len     (i_wr_length),
        .i_byte    (i_wr_byte),
        .o_pos     (wr_pos),
        .o_lap     (wr_lap),
        .o_st_en   (st_wr_en),
        .o_st_addr (st_wr_addr),
        .o_st_data (st_wr_data),
        .o_fl_en   (fl_wr_en),
        .o_fl_addr (fl_wr_addr),
        .o_fl_data (fl_wr_data)
    );

    orsb_byte_ram #(
        .AW (AW),
        .DW (BYTE_W)
    ) u_byte_ram (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_q)
    );

    orsb_fill_ram #(
        .SLOTS (SLOTS),
        .FW    (FW)
    ) u_fill_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (fl_wr_en),
        .i_wr_addr (fl_wr_addr),
        .i_wr_data (fl_wr_data),
        .i_rd_en   (fl_rd_en),
        .i_rd_addr (fl_rd_addr),
        .o_rd_data (fl_q)
    );

    orsb_reader #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_reader (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (rd_req),
        .i_lap          (i_rd_lap),
        .i_pos          (i_rd_position),
        .i_lim          (i_rd_max_bytes),
        .o_idle         (rd_idle),
        .i_wr_pos       (wr_pos),
        .i_wr_lap       (wr_lap),
        .o_fl_rd_en     (fl_rd_en),
        .o_fl_rd_addr   (fl_rd_addr),
        .i_fl_q         (fl_q),
        .o_st_rd_en     (st_rd_en),
        .o_st_rd_addr   (st_rd_addr),
        .i_st_q         (st_q),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_rd_byte      (o_rd_byte),
        .o_rd_has_data  (o_rd_has_data),
        .o_rd_last      (o_rd_last),
        .o_out_lap      (o_out_lap),
        .o_out_position (o_out_position)
    );

endmodule

[hw/rtl/orsb_byte_ram.sv]
module orsb_byte_ram #(
    parameter int AW = 9,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_q;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data held until the next enabled read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

[hw/rtl/orsb_fill_ram.sv]
module orsb_fill_ram #(
    parameter int SLOTS = 8,
    parameter int FW    = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_wr_en,
    input  logic [$clog2(SLOTS)-1:0] i_wr_addr,
    input  logic [FW-1:0]            i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(SLOTS)-1:0] i_rd_addr,
    output logic [FW-1:0]            o_rd_data
);

    logic [FW-1:0]    mem [SLOTS];
    logic [SLOTS-1:0] r_vld;
    logic [FW-1:0]    r_q;
    logic             r_q_vld;

    // Fill lengths, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    // Per-slot valid bits; an unwritten slot reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule

[hw/rtl/orsb_writer.sv]
module orsb_writer #(
    parameter int SLOTS      = 8,
    parameter int SLOT_BYTES = 64
) (
    i_clk, i_rst_n, i_en, i_first, i_len, i_byte,
    o_pos, o_lap,
    o_st_en, o_st_addr, o_st_data,
    o_fl_en, o_fl_addr, o_fl_data
);
    import orsb_pkg::*;

    localparam int SW  = $clog2(SLOTS);
    localparam int PW  = SW + 1;
    localparam int BIW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int AW  = SW + BIW;
    localparam int FW  = $clog2(SLOT_BYTES + 1);

    input  logic                   i_clk;
    input  logic                   i_rst_n;
    input  logic                   i_en;
    input  logic                   i_first;
    input  logic [LEN_W-1:0]       i_len;
    input  logic [BYTE_W-1:0]      i_byte;
    output logic signed [PW-1:0]   o_pos;
    output logic [LAP_W-1:0]       o_lap;
    output logic                   o_st_en;
    output logic [AW-1:0]          o_st_addr;
    output logic [BYTE_W-1:0]      o_st_data;
    output logic                   o_fl_en;
    output logic [SW-1:0]          o_fl_addr;
    output logic [FW-1:0]          o_fl_data;

    logic signed [PW-1:0] r_pos, n_pos;
    logic [LAP_W-1:0]     r_lap, n_lap;
    logic [LEN_W-1:0]     r_idx, n_idx;
    logic [LEN_W-1:0]     r_len, n_len;
    logic                 r_drop, n_drop;

    logic                 wrap;
    logic signed [PW-1:0] next_pos;
    logic                 pos_ok;

    // Cursor advance: wrap to slot 0 bumps the lap
    assign wrap     = (r_pos == PW'(SLOTS - 1));
    assign next_pos = wrap ? '0 : r_pos + PW'(1);
    assign pos_ok   = !r_pos[PW-1];

    // Write item decode
    always_comb begin
        n_pos     = r_pos;
        n_lap     = r_lap;
        n_idx     = r_idx;
        n_len     = r_len;
        n_drop    = r_drop;
        o_st_en   = 1'b0;
        o_st_addr = {r_pos[SW-1:0], r_idx[BIW-1:0]};
        o_fl_en   = 1'b0;
        o_fl_addr = r_pos[SW-1:0];
        if (i_en) begin
            if (i_first) begin
                n_len = i_len;
                n_idx = '0;
                if (i_len > LEN_W'(SLOT_BYTES)) begin
                    n_drop = 1'b1;
                end else begin
                    n_drop    = 1'b0;
                    n_pos     = next_pos;
                    n_lap     = wrap ? r_lap + LAP_W'(1) : r_lap;
                    o_fl_addr = next_pos[SW-1:0];
                    if (i_len == '0) begin
                        o_fl_en = 1'b1;
                    end else begin
                        o_st_en   = 1'b1;
                        o_st_addr = {next_pos[SW-1:0], {BIW{1'b0}}};
                        n_idx     = LEN_W'(1);
                        o_fl_en   = (i_len == LEN_W'(1));
                    end
                end
            end else if (r_idx < r_len) begin
                n_idx = r_idx + LEN_W'(1);
                if (r_drop) begin
                    if (n_idx >= r_len) begin
                        n_drop = 1'b0;
                    end
                end else begin
                    o_st_en = pos_ok && (r_idx < LEN_W'(SLOT_BYTES));
                    o_fl_en = pos_ok && (n_idx >= r_len);
                end
            end
        end
    end

    assign o_st_data = i_byte;
    assign o_fl_data = FW'(n_len);
    assign o_pos     = r_pos;
    assign o_lap     = r_lap;

    // Writer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '1;
            r_lap  <= '0;
            r_idx  <= '0;
            r_len  <= '0;
            r_drop <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_lap  <= n_lap;
            r_idx  <= n_idx;
            r_len  <= n_len;
            r_drop <= n_drop;
        end
    end

endmodule

[hw/rtl/orsb_reader.sv]
module orsb_reader #(
    parameter int SLOTS      = 8,
    parameter int SLOT_BYTES = 64
) (
    i_clk, i_rst_n, i_req, i_lap, i_pos, i_lim, o_idle,
    i_wr_pos, i_wr_lap,
    o_fl_rd_en, o_fl_rd_addr, i_fl_q,
    o_st_rd_en, o_st_rd_addr, i_st_q,
    o_out_valid, i_out_ready, o_rd_byte, o_rd_has_data, o_rd_last,
    o_out_lap, o_out_position
);
    import orsb_pkg::*;

    localparam int SW   = $clog2(SLOTS);
    localparam int PW   = SW + 1;
    localparam int CMPW = ((PW > IPOS_W) ? PW : IPOS_W) + 1;
    localparam int BIW  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int AW   = SW + BIW;
    localparam int FW   = $clog2(SLOT_BYTES + 1);
    localparam int CW   = $clog2(SLOT_BYTES + 1);
    localparam logic signed [CMPW-1:0] SLOTS_S = CMPW'(SLOTS);

    input  logic                      i_clk;
    input  logic                      i_rst_n;
    input  logic                      i_req;
    input  logic [LAP_W-1:0]          i_lap;
    input  logic signed [IPOS_W-1:0]  i_pos;
    input  logic [LIM_W-1:0]          i_lim;
    output logic                      o_idle;
    input  logic signed [PW-1:0]      i_wr_pos;
    input  logic [LAP_W-1:0]          i_wr_lap;
    output logic                      o_fl_rd_en;
    output logic [SW-1:0]             o_fl_rd_addr;
    input  logic [FW-1:0]             i_fl_q;
    output logic                      o_st_rd_en;
    output logic [AW-1:0]             o_st_rd_addr;
    input  logic [BYTE_W-1:0]         i_st_q;
    output logic                      o_out_valid;
    input  logic                      i_out_ready;
    output logic [BYTE_W-1:0]         o_rd_byte;
    output logic                      o_rd_has_data;
    output logic                      o_rd_last;
    output logic [LAP_W-1:0]          o_out_lap;
    output logic signed [IPOS_W-1:0]  o_out_position;

    t_rd_state r_state, n_state;

    logic [LAP_W-1:0]         r_lap;
    logic signed [CMPW-1:0]   r_pos;
    logic [LIM_W-1:0]         r_lim;
    logic [CW-1:0]            r_cnt;
    logic [CW-1:0]            r_idx;
    logic                     r_ovalid;
    logic                     r_ohas;
    logic                     r_olast;
    logic [LAP_W-1:0]         r_olap;
    logic signed [IPOS_W-1:0] r_opos;

    logic signed [CMPW-1:0] wpos_x;
    logic                   lapped;
    logic                   wrap;
    logic signed [CMPW-1:0] cu_pos;
    logic [LAP_W-1:0]       cu_lap;
    logic                   pos_ok;
    logic                   out_free;
    logic [LIM_W-1:0]       fill_x;
    logic [LIM_W-1:0]       n_lim;
    logic [LIM_W-1:0]       n_bytes;
    logic [CW-1:0]          idx_inc;
    logic                   load_empty;

    // Catch-up check against the writer cursor
    assign wpos_x = {{(CMPW - PW){i_wr_pos[PW-1]}}, i_wr_pos};
    assign lapped = ((r_pos <= wpos_x) && (r_lap < i_wr_lap)) ||
                    ((r_lap + LAP_W'(1)) < i_wr_lap);
    assign wrap   = (i_wr_pos == PW'(SLOTS - 1));
    assign cu_pos = wrap ? '0 : wpos_x + CMPW'(1);
    assign cu_lap = wrap ? i_wr_lap : i_wr_lap - LAP_W'(1);

    assign pos_ok   = (r_pos >= 0) && (r_pos < SLOTS_S);
    assign out_free = !r_ovalid || i_out_ready;

    // Byte count: min of limit, fill and slot size
    assign fill_x  = LIM_W'(i_fl_q);
    assign n_lim   = (r_lim < fill_x) ? r_lim : fill_x;
    assign n_bytes = (n_lim > LIM_W'(SLOT_BYTES)) ? LIM_W'(SLOT_BYTES) : n_lim;
    assign idx_inc = r_idx + CW'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            RD_IDLE:   if (i_req) n_state = RD_CATCH;
            RD_CATCH:  n_state = RD_FILL;
            RD_FILL:   n_state = pos_ok ? RD_LEN : RD_EMPTY;
            RD_LEN:    n_state = (n_bytes == '0) ? RD_EMPTY : RD_STREAM;
            RD_STREAM: if (out_free && (idx_inc == r_cnt)) n_state = RD_IDLE;
            RD_EMPTY:  if (out_free) n_state = RD_IDLE;
            default:   n_state = RD_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_idle     = 1'b0;
        o_fl_rd_en = 1'b0;
        o_st_rd_en = 1'b0;
        load_empty = 1'b0;
        unique case (r_state)
            RD_IDLE:   o_idle = 1'b1;
            RD_CATCH:  ;
            RD_FILL:   o_fl_rd_en = pos_ok;
            RD_LEN:    ;
            RD_STREAM: o_st_rd_en = out_free;
            RD_EMPTY:  load_empty = out_free;
            default:   ;
        endcase
    end

    assign o_fl_rd_addr = r_pos[SW-1:0];
    assign o_st_rd_addr = {r_pos[SW-1:0], r_idx[BIW-1:0]};

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= RD_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_st_rd_en || load_empty) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Cursor, counters and output beat
    always_ff @(posedge i_clk) begin
        if (o_idle && i_req) begin
            r_lap <= i_lap;
            r_pos <= {{(CMPW - IPOS_W){i_pos[IPOS_W-1]}}, i_pos};
            r_lim <= i_lim;
        end
        if ((r_state == RD_CATCH) && lapped) begin
            r_lap <= cu_lap;
            r_pos <= cu_pos;
        end
        if (r_state == RD_LEN) begin
            r_cnt <= CW'(n_bytes);
            r_idx <= '0;
        end
        if (o_st_rd_en) begin
            r_idx   <= idx_inc;
            r_ohas  <= 1'b1;
            r_olast <= (idx_inc == r_cnt);
            r_olap  <= r_lap;
            r_opos  <= r_pos[IPOS_W-1:0];
        end else if (load_empty) begin
            r_ohas  <= 1'b0;
            r_olast <= 1'b1;
            r_olap  <= r_lap;
            r_opos  <= r_pos[IPOS_W-1:0];
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_rd_byte      = r_ohas ? i_st_q : '0;
    assign o_rd_has_data  = r_ohas;
    assign o_rd_last      = r_olast;
    assign o_out_lap      = r_olap;
    assign o_out_position = r_opos;

endmodule
